/* src/edpw_pkg.sv */
`timescale 1ns / 1ps

package edpw_pkg;

  localparam int MaxNodesDefault = 256;
  localparam int MaxKDefault     = 8;
  localparam int WordsPerNode    = 12;
  localparam int WeightBits      = 16;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 9;

  localparam logic [CfgIndexWidth-1:0] CfgActiveNodes = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgKNeighbors  = 2'd1;

  localparam logic [8:0] ActiveNodesReset = 9'd0;
  localparam logic [3:0] KNeighborsReset  = 4'd4;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindPoint = 1'b1;

  typedef struct packed {
    logic               kind;
    logic               load_ok;
    logic [7:0]         node_index;
    logic [3:0]         word_select;
    logic signed [31:0] word_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } edpw_item_t;

endpackage

/* src/embedded_deformation_point_warp_top.sv */
`timescale 1ns / 1ps

// Channel   Handshake             Beat
// input     start / busy          kind, node_index, word_select, word_value, point_x/y/z
// result    result_valid_o        warped_x/y/z, exact_hit, neighbors_used
// config    cfg_we_i              cfg_index_i, cfg_wdata_i
//
// The back end writes a load beat into the node table while it is idle. The time a point takes
// is set by the distance scan over the single read port of the node table and the serial
// dividers; an exact hit ends before the final divide, and a point with no active nodes
// returns zero results without a blend.
// Reset clears control state only; the node table holds garbage until written.
// A two-beat queue lets the front take beats while a point is in work; results cannot be held off.

module embedded_deformation_point_warp_top import edpw_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDefault,
  parameter int MAX_K     = MaxKDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     kind_i,
  input  logic [7:0]               node_index_i,
  input  logic [3:0]               word_select_i,
  input  logic signed [31:0]       word_value_i,
  input  logic signed [31:0]       point_x_i,
  input  logic signed [31:0]       point_y_i,
  input  logic signed [31:0]       point_z_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_wdata_i,
  output logic                     result_valid_o,
  output logic signed [31:0]       warped_x_o,
  output logic signed [31:0]       warped_y_o,
  output logic signed [31:0]       warped_z_o,
  output logic                     exact_hit_o,
  output logic [3:0]               neighbors_used_o
);

  logic [8:0] active_nodes_q;
  logic [3:0] k_neighbors_q;
  logic       item_valid, item_ready;
  edpw_item_t item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_nodes_q <= ActiveNodesReset;
      k_neighbors_q  <= KNeighborsReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgActiveNodes) active_nodes_q <= cfg_wdata_i;
      if (cfg_index_i == CfgKNeighbors)  k_neighbors_q  <= cfg_wdata_i[3:0];
    end
  end

  edpw_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .kind_i,
    .node_index_i,
    .word_select_i,
    .word_value_i,
    .point_x_i,
    .point_y_i,
    .point_z_i,
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_ready_i(item_ready)
  );

  edpw_engine #(
    .MAX_NODES(MAX_NODES),
    .MAX_K    (MAX_K)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_ready_o    (item_ready),
    .active_nodes_i  (active_nodes_q),
    .k_neighbors_i   (k_neighbors_q),
    .result_valid_o,
    .warped_x_o,
    .warped_y_o,
    .warped_z_o,
    .exact_hit_o,
    .neighbors_used_o
  );

endmodule

/* src/edpw_front.sv */
`timescale 1ns / 1ps

module edpw_front import edpw_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic [7:0]         node_index_i,
  input  logic [3:0]         word_select_i,
  input  logic signed [31:0] word_value_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               item_valid_o,
  output edpw_item_t         item_o,
  input  logic               item_ready_i
);

  edpw_item_t queue_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       push, pop;
  edpw_item_t incoming;

  assign busy         = (count_q == 2'd2);
  assign push         = start && !busy;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = queue_q[rptr_q];

  // A load beat that points outside the table is marked here so the back end drops it.
  always_comb begin
    incoming.kind        = kind_i;
    incoming.load_ok     = (32'(node_index_i) < MAX_NODES) && (word_select_i < 4'(WordsPerNode));
    incoming.node_index  = node_index_i;
    incoming.word_select = word_select_i;
    incoming.word_value  = word_value_i;
    incoming.point_x     = point_x_i;
    incoming.point_y     = point_y_i;
    incoming.point_z     = point_z_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= incoming;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

/* src/edpw_engine.sv */
`timescale 1ns / 1ps

module edpw_engine import edpw_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDefault,
  parameter int MAX_K     = MaxKDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  edpw_item_t         item_i,
  output logic               item_ready_o,
  input  logic [8:0]         active_nodes_i,
  input  logic [3:0]         k_neighbors_i,
  output logic               result_valid_o,
  output logic signed [31:0] warped_x_o,
  output logic signed [31:0] warped_y_o,
  output logic signed [31:0] warped_z_o,
  output logic               exact_hit_o,
  output logic [3:0]         neighbors_used_o
);

  localparam int Depth = MAX_NODES * WordsPerNode;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int NIW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NCW   = $clog2(MAX_NODES + 1);
  localparam int KW    = $clog2(MAX_K + 1);
  localparam int KIW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int QW    = 37;
  localparam int WW    = WeightBits + 1;
  localparam int PWW   = WW + QW;
  localparam int WSW   = WW + $clog2(MAX_K);
  localparam int SUMW  = PWW + $clog2(MAX_K) + 1;
  localparam int DCW   = $clog2(SUMW + 1);

  typedef enum logic [2:0] {
    StIdle, StScan, StPick, StBlend, StDivInit, StDiv
  } state_e;

  state_e state_q;

  logic signed [31:0] table_q [Depth];
  logic signed [31:0] rdata_q;
  logic [AW-1:0]      raddr, waddr;
  logic               we;

  logic signed [31:0] p_q [3];
  logic [NCW-1:0]     nact_q, n_q;
  logic [KW-1:0]      k_q, cnt_q, bi_q;
  logic [2:0]         ph_q;
  logic [63:0]        sq_q, acc_q;
  logic [63:0]        best_d_q [MAX_K];
  logic [NIW-1:0]     best_i_q [MAX_K];
  logic               exact_q;
  logic [4:0]         step_q;
  logic signed [32:0] d_q [3];
  logic signed [QW-1:0] q_q [3];
  logic signed [64:0] prod_q;
  logic [1:0]         prow_q, row_q, col_q;
  logic               pv_q;
  logic [63:0]        wr_q, wden_q;
  logic [WeightBits-1:0] wq_q;
  logic               wfull_q;
  logic signed [PWW-1:0] prodw_q [3];
  logic signed [SUMW-1:0] sum_q [3];
  logic [WSW-1:0]     wsum_q;
  logic [SUMW-1:0]    num_q [3];
  logic [SUMW-1:0]    quo_q [3];
  logic [WSW-1:0]     rem_q [3];
  logic               neg_q [3];
  logic [DCW-1:0]     dcnt_q;

  function automatic logic [AW-1:0] base_addr(input logic [NIW-1:0] n);
    base_addr = AW'({n, 3'b000}) + AW'({n, 2'b00});
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_sat = s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic signed [31:0] sat_q(input logic signed [QW-1:0] v);
    if (v > QW'(64'sd2147483647))       sat_q = 32'sh7FFF_FFFF;
    else if (v < QW'(-64'sd2147483648)) sat_q = 32'sh8000_0000;
    else                                sat_q = v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_quo(input logic neg, input logic [SUMW-1:0] q);
    if (neg) sat_quo = (q > SUMW'(64'd2147483648)) ? 32'sh8000_0000 : -q[31:0];
    else     sat_quo = (q > SUMW'(64'd2147483647)) ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  // Node table port.
  logic [NIW-1:0] node_sel;
  logic [3:0]     word_sel;

  always_comb begin
    if (state_q == StScan) begin
      node_sel = n_q[NIW-1:0];
      word_sel = (ph_q < 3'd3) ? 4'(ph_q) : 4'd0;
    end else begin
      node_sel = best_i_q[bi_q[KIW-1:0]];
      word_sel = (step_q < 5'(WordsPerNode)) ? step_q[3:0] : 4'd0;
    end
  end

  assign raddr = base_addr(node_sel) + AW'(word_sel);
  assign waddr = base_addr(NIW'(item_i.node_index)) + AW'(item_i.word_select);
  assign item_ready_o = (state_q == StIdle);
  assign we = item_valid_i && item_ready_o && (item_i.kind == KindLoad) && item_i.load_ok;

  always_ff @(posedge clk_i) begin
    if (we) table_q[waddr] <= item_i.word_value;
    rdata_q <= table_q[raddr];
  end

  // Distance of the current coordinate.
  logic signed [31:0] p_sel;
  logic signed [32:0] diff, absd;
  logic [63:0]        sq_d;

  always_comb begin
    unique case (ph_q)
      3'd1:    p_sel = p_q[0];
      3'd2:    p_sel = p_q[1];
      default: p_sel = p_q[2];
    endcase
    diff = 33'(p_sel) - 33'(rdata_q);
    absd = diff[32] ? -diff : diff;
    sq_d = absd[31:0] * absd[31:0];
  end

  // Sorted insertion into the nearest list; equal distances keep the earlier node first.
  logic [KW-1:0] pos;
  logic          skip;
  logic [63:0]   ins_d [MAX_K];
  logic [NIW-1:0] ins_i [MAX_K];

  always_comb begin
    pos = '0;
    for (int j = 0; j < MAX_K; j++) begin
      pos = pos + KW'((KW'(j) < cnt_q) && (best_d_q[j] <= acc_q));
    end
    skip = (cnt_q == k_q) && (pos >= k_q);
    for (int j = 0; j < MAX_K; j++) begin
      if (KW'(j) == pos) begin
        ins_d[j] = acc_q;
        ins_i[j] = n_q[NIW-1:0];
      end else if ((KW'(j) > pos) && (j > 0)) begin
        ins_d[j] = best_d_q[(j > 0) ? j - 1 : 0];
        ins_i[j] = best_i_q[(j > 0) ? j - 1 : 0];
      end else begin
        ins_d[j] = best_d_q[j];
        ins_i[j] = best_i_q[j];
      end
    end
  end

  // Rounded matrix term and blend weight.
  logic signed [65:0]    rsum;
  logic signed [QW-1:0]  term;
  logic [64:0]           wr_sh;
  logic [WW-1:0]         w;
  logic signed [64:0]    prod_d;

  always_comb begin
    rsum   = 66'(prod_q) + 66'sd536870912;
    term   = QW'(rsum >>> 30);
    wr_sh  = {wr_q, 1'b0};
    w      = wfull_q ? WW'(1 << WeightBits) : {1'b0, wq_q};
    prod_d = rdata_q * d_q[col_q];
  end

  logic [NCW-1:0] nact_d;
  logic [KW-1:0]  k_d;

  always_comb begin
    nact_d = (32'(active_nodes_i) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(active_nodes_i);
    if (k_neighbors_i == 4'd0)          k_d = KW'(1);
    else if (32'(k_neighbors_i) > MAX_K) k_d = KW'(MAX_K);
    else                                 k_d = KW'(k_neighbors_i);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StScan && ph_q == 3'd5 && !skip) begin
      for (int j = 0; j < MAX_K; j++) begin
        if (KW'(j) < k_q) begin
          best_d_q[j] <= ins_d[j];
          best_i_q[j] <= ins_i[j];
        end
      end
    end
  end

  logic [WSW:0] r2 [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      r2[a] = {rem_q[a], num_q[a][SUMW-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      cnt_q            <= '0;
      k_q              <= KW'(1);
      result_valid_o   <= 1'b0;
      warped_x_o       <= '0;
      warped_y_o       <= '0;
      warped_z_o       <= '0;
      exact_hit_o      <= 1'b0;
      neighbors_used_o <= '0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (item_valid_i && item_i.kind == KindPoint) begin
            p_q[0]  <= item_i.point_x;
            p_q[1]  <= item_i.point_y;
            p_q[2]  <= item_i.point_z;
            nact_q  <= nact_d;
            k_q     <= k_d;
            n_q     <= '0;
            ph_q    <= 3'd0;
            cnt_q   <= '0;
            state_q <= StScan;
          end
        end
        StScan: begin
          unique case (ph_q)
            3'd0: begin
              if (n_q == nact_q) state_q <= StPick;
              else               ph_q    <= 3'd1;
            end
            3'd1: begin
              sq_q <= sq_d;
              ph_q <= 3'd2;
            end
            3'd2: begin
              sq_q  <= sq_d;
              acc_q <= sq_q;
              ph_q  <= 3'd3;
            end
            3'd3: begin
              sq_q  <= sq_d;
              acc_q <= add_sat(acc_q, sq_q);
              ph_q  <= 3'd4;
            end
            3'd4: begin
              acc_q <= add_sat(acc_q, sq_q);
              ph_q  <= 3'd5;
            end
            default: begin
              if (!skip && cnt_q < k_q) cnt_q <= cnt_q + KW'(1);
              n_q  <= n_q + NCW'(1);
              ph_q <= 3'd0;
            end
          endcase
        end
        StPick: begin
          if (cnt_q == '0) begin
            result_valid_o   <= 1'b1;
            warped_x_o       <= '0;
            warped_y_o       <= '0;
            warped_z_o       <= '0;
            exact_hit_o      <= 1'b0;
            neighbors_used_o <= '0;
            state_q          <= StIdle;
          end else begin
            exact_q <= (best_d_q[0] == 64'd0);
            bi_q    <= '0;
            step_q  <= '0;
            wsum_q  <= '0;
            for (int a = 0; a < 3; a++) sum_q[a] <= '0;
            state_q <= StBlend;
          end
        end
        StBlend: begin
          step_q <= step_q + 5'd1;
          if (step_q >= 5'd1 && step_q <= 5'd3) begin
            d_q[step_q[1:0] - 2'd1] <= 33'(p_q[step_q[1:0] - 2'd1]) - 33'(rdata_q);
            q_q[step_q[1:0] - 2'd1] <= QW'(rdata_q);
            row_q <= 2'd0;
            col_q <= 2'd0;
          end
          if (step_q >= 5'd4 && step_q <= 5'd12) begin
            prod_q <= prod_d;
            prow_q <= row_q;
            pv_q   <= 1'b1;
            if (col_q == 2'd2) begin
              col_q <= 2'd0;
              row_q <= row_q + 2'd1;
            end else begin
              col_q <= col_q + 2'd1;
            end
          end else begin
            pv_q <= 1'b0;
          end
          if (pv_q) q_q[prow_q] <= q_q[prow_q] + term;
          if (step_q == 5'd0) begin
            wr_q    <= best_d_q[0];
            wden_q  <= best_d_q[bi_q[KIW-1:0]];
            wfull_q <= best_d_q[0] >= best_d_q[bi_q[KIW-1:0]];
            wq_q    <= '0;
          end else if (step_q <= 5'(WeightBits)) begin
            if (wr_sh >= {1'b0, wden_q}) begin
              wr_q <= 64'(wr_sh - {1'b0, wden_q});
              wq_q <= {wq_q[WeightBits-2:0], 1'b1};
            end else begin
              wr_q <= wr_sh[63:0];
              wq_q <= {wq_q[WeightBits-2:0], 1'b0};
            end
          end
          if (step_q == 5'd17) begin
            if (exact_q) begin
              result_valid_o   <= 1'b1;
              warped_x_o       <= sat_q(q_q[0]);
              warped_y_o       <= sat_q(q_q[1]);
              warped_z_o       <= sat_q(q_q[2]);
              exact_hit_o      <= 1'b1;
              neighbors_used_o <= 4'd1;
              state_q          <= StIdle;
            end else begin
              for (int a = 0; a < 3; a++) prodw_q[a] <= $signed({1'b0, w}) * q_q[a];
            end
          end
          if (step_q == 5'd18) begin
            for (int a = 0; a < 3; a++) sum_q[a] <= sum_q[a] + SUMW'(prodw_q[a]);
            wsum_q <= wsum_q + WSW'(w);
            step_q <= '0;
            bi_q   <= bi_q + KW'(1);
            if (bi_q + KW'(1) == cnt_q) state_q <= StDivInit;
          end
        end
        StDivInit: begin
          for (int a = 0; a < 3; a++) begin
            neg_q[a] <= sum_q[a][SUMW-1];
            num_q[a] <= (sum_q[a][SUMW-1] ? SUMW'(-sum_q[a]) : SUMW'(sum_q[a]))
                        + SUMW'(wsum_q >> 1);
            rem_q[a] <= '0;
            quo_q[a] <= '0;
          end
          dcnt_q  <= DCW'(SUMW);
          state_q <= StDiv;
        end
        default: begin
          if (dcnt_q == '0) begin
            result_valid_o   <= 1'b1;
            warped_x_o       <= sat_quo(neg_q[0], quo_q[0]);
            warped_y_o       <= sat_quo(neg_q[1], quo_q[1]);
            warped_z_o       <= sat_quo(neg_q[2], quo_q[2]);
            exact_hit_o      <= 1'b0;
            neighbors_used_o <= 4'(cnt_q);
            state_q          <= StIdle;
          end else begin
            dcnt_q <= dcnt_q - DCW'(1);
            for (int a = 0; a < 3; a++) begin
              num_q[a] <= num_q[a] << 1;
              if (r2[a] >= {1'b0, wsum_q}) begin
                rem_q[a] <= WSW'(r2[a] - {1'b0, wsum_q});
                quo_q[a] <= {quo_q[a][SUMW-2:0], 1'b1};
              end else begin
                rem_q[a] <= r2[a][WSW-1:0];
                quo_q[a] <= {quo_q[a][SUMW-2:0], 1'b0};
              end
            end
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_within_k: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= k_q)
    else $error("nearest list holds more nodes than k");
  a_exact_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && exact_hit_o |-> neighbors_used_o == 4'd1)
    else $error("exact hit blended more than one node");
  a_blend_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StBlend |-> bi_q < cnt_q)
    else $error("blend index ran past the nearest list");
`endif

endmodule
